// ===== rtl/kst_pkg.sv =====
package kst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 32;
    localparam int REF_W    = 32;
    localparam int STATUS_W = 3;
    localparam int FIDX_W   = 6;
    localparam int FCNT_W   = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_POP    = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_DUP       = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_RESOLVE = 2'd1,
        S_SHIFT   = 2'd2
    } state_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic capture;
        logic pop_mode;
        logic valid;
        logic last;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/kst_ifs.sv =====
interface kst_req_if import kst_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic [REF_W-1:0]        entry_ref;

    modport source (output valid, func, key, entry_ref, input ready);
    modport sink   (input valid, func, key, entry_ref, output ready);
endinterface

interface kst_rsp_if import kst_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [REF_W-1:0]    found_ref;
    logic [FIDX_W-1:0]   found_index;
    logic [FCNT_W-1:0]   entry_count;

    modport source (output valid, status, found_ref, found_index, entry_count, input ready);
    modport sink   (input valid, status, found_ref, found_index, entry_count, output ready);
endinterface

// ===== rtl/kst_cell.sv =====
module kst_cell import kst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] cmp_key,
    input  logic [KEY_W-1:0] load_key,
    input  logic [REF_W-1:0] load_ref,
    input  logic [KEY_W-1:0] nbr_key,
    input  logic [REF_W-1:0] nbr_ref,
    output logic [KEY_W-1:0] key_q,
    output logic [REF_W-1:0] ref_q,
    output logic             hit
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [REF_W-1:0] ref_reg;
    logic [REF_W-1:0] ref_next;
    logic             hit_reg;
    logic             hit_next;

    // A new entry is written here, or the upper neighbor's entry moves down.
    // Otherwise the cell keeps its entry.
    always_comb
    begin
        key_next = key_reg;
        ref_next = ref_reg;
        priority if (ctrl.load)
        begin
            key_next = load_key;
            ref_next = load_ref;
        end
        else if (ctrl.shift)
        begin
            key_next = nbr_key;
            ref_next = nbr_ref;
        end
        else
        begin
            key_next = key_reg;
            ref_next = ref_reg;
        end
    end

    // The hit bit is taken when a word is accepted: a key match, or for pop
    // the last occupied cell.
    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.capture)
        begin
            hit_next = ctrl.valid & (ctrl.pop_mode ? ctrl.last : (key_reg == cmp_key));
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        ref_reg <= ref_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign key_q = key_reg;
    assign ref_q = ref_reg;
    assign hit   = hit_reg;

endmodule

// ===== rtl/kst_reduce.sv =====
module kst_reduce import kst_pkg::*;
(
    input  logic [CAPACITY-1:0] hit,
    input  logic [REF_W-1:0]    refs [CAPACITY],
    output logic                any_hit,
    output logic [IDX_W-1:0]    hit_idx,
    output logic [REF_W-1:0]    hit_ref
);

    // Keys are unique in the table, so at most one hit bit is set and a
    // plain OR of the gated terms selects it.
    always_comb
    begin
        hit_idx = '0;
        hit_ref = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_idx = hit_idx | (hit[i] ? IDX_W'(i) : '0);
            hit_ref = hit_ref | (hit[i] ? refs[i] : '0);
        end
    end

    assign any_hit = |hit;

endmodule

// ===== rtl/keyed_set_table_unit.sv =====
// Sequence: a word accepted at an edge is compared in all cells at that edge, then
// resolved in S_RESOLVE, and shows on rsp from the output register once resolve completes.
// A new word is taken only in S_IDLE; a remove that finds its key passes through S_SHIFT,
// the shift of every later entry one cell down the cell row.
// A result not yet taken on rsp holds back the resolve cycle of the next word.
// Reset: the state, entry count and output valid clear at once; cell entries are not cleared.
module keyed_set_table_unit import kst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    kst_req_if.sink   req,
    kst_rsp_if.source rsp
);

    // Sequencer state and the captured request word.
    state_t           state_reg;
    state_t           state_next;
    func_t            op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [REF_W-1:0] ref_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] fidx_reg;
    logic [IDX_W-1:0] fidx_next;

    // Output register, which lets a finished result wait while a new word
    // is already being compared.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [REF_W-1:0]    fref_reg;
    logic [REF_W-1:0]    fref_next;
    logic [FIDX_W-1:0]   oidx_reg;
    logic [FIDX_W-1:0]   oidx_next;
    logic [FCNT_W-1:0]   ocnt_reg;
    logic [FCNT_W-1:0]   ocnt_next;

    logic accept;
    logic fire;
    logic load_en;

    logic [CAPACITY-1:0] hit;
    logic [KEY_W-1:0]    key_q   [CAPACITY];
    logic [REF_W-1:0]    ref_q   [CAPACITY];
    logic [KEY_W-1:0]    nbr_key [CAPACITY];
    logic [REF_W-1:0]    nbr_ref [CAPACITY];
    cell_ctrl_t          ctrl    [CAPACITY];

    logic             any_hit;
    logic [IDX_W-1:0] hit_idx;
    logic [REF_W-1:0] hit_ref;

    // A new word is taken only when the sequencer is idle; the result of the
    // previous word may still be waiting in the output register.
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid & req.ready;

    // The resolve cycle completes once the output register is free.
    assign fire = (state_reg == S_RESOLVE) & (~out_valid_reg | rsp.ready);

    // The cell row. Each cell owns one table position and, during a shift,
    // takes the entry of its upper neighbor. The top cell keeps its own.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == CAPACITY - 1)
        begin : g_top
            assign nbr_key[g] = key_q[g];
            assign nbr_ref[g] = ref_q[g];
        end
        else
        begin : g_mid
            assign nbr_key[g] = key_q[g+1];
            assign nbr_ref[g] = ref_q[g+1];
        end

        assign ctrl[g].capture  = accept;
        assign ctrl[g].pop_mode = (func_t'(req.func) == FN_POP);
        assign ctrl[g].valid    = (count_reg > CNT_W'(g));
        assign ctrl[g].last     = (count_reg == CNT_W'(g + 1));
        assign ctrl[g].load     = load_en & (count_reg == CNT_W'(g));
        assign ctrl[g].shift    = (state_reg == S_SHIFT) & (fidx_reg <= IDX_W'(g));

        kst_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl[g]),
            .cmp_key  (req.key),
            .load_key (key_reg),
            .load_ref (ref_reg),
            .nbr_key  (nbr_key[g]),
            .nbr_ref  (nbr_ref[g]),
            .key_q    (key_q[g]),
            .ref_q    (ref_q[g]),
            .hit      (hit[g])
        );
    end

    kst_reduce u_reduce
    (
        .hit     (hit),
        .refs    (ref_q),
        .any_hit (any_hit),
        .hit_idx (hit_idx),
        .hit_ref (hit_ref)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (fire)
                begin
                    state_next = (op_reg == FN_REMOVE && any_hit) ? S_SHIFT : S_IDLE;
                end
            end
            S_SHIFT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result and table update. A removal records the hit position so that
    // the following shift cycle moves every later entry down one cell.
    always_comb
    begin
        count_next     = count_reg;
        fidx_next      = fidx_reg;
        load_en        = 1'b0;
        out_valid_next = out_valid_reg & ~rsp.ready;
        status_next    = status_reg;
        fref_next      = fref_reg;
        oidx_next      = oidx_reg;
        ocnt_next      = ocnt_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_DONE;
            fref_next      = '0;
            oidx_next      = '0;
            fidx_next      = hit_idx;
            unique case (op_reg)
                FN_ADD:
                begin
                    if (any_hit)
                    begin
                        status_next = ST_DUP;
                        oidx_next   = FIDX_W'(hit_idx);
                    end
                    else if (count_reg == CNT_W'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        load_en    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FN_REMOVE, FN_POP:
                begin
                    if (any_hit)
                    begin
                        fref_next  = hit_ref;
                        oidx_next  = FIDX_W'(hit_idx);
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = (op_reg == FN_POP) ? ST_EMPTY : ST_NOT_FOUND;
                    end
                end
                FN_LOOKUP:
                begin
                    if (any_hit)
                    begin
                        fref_next = hit_ref;
                        oidx_next = FIDX_W'(hit_idx);
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    status_next = ST_NOT_FOUND;
                end
            endcase
            ocnt_next = FCNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= func_t'(req.func);
            key_reg <= req.key;
            ref_reg <= req.entry_ref;
        end
        fidx_reg   <= fidx_next;
        status_reg <= status_next;
        fref_reg   <= fref_next;
        oidx_reg   <= oidx_next;
        ocnt_reg   <= ocnt_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_ref   = fref_reg;
    assign rsp.found_index = oidx_reg;
    assign rsp.entry_count = ocnt_reg;

    // The entry count never passes the capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Keys are unique, so no more than one cell can report a hit.
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESOLVE |-> $onehot0(hit))
        else $error("more than one cell hit");

    // The entry count moves only as a resolve cycle completes.
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(fire))
        else $error("entry count changed outside resolve");

    // A new result appears only from a completed resolve cycle.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire))
        else $error("result without resolve");

    // A shift is never repeated and follows directly on the resolve of a successful removal.
    a_shift_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> $past(state_reg) == S_RESOLVE && $past(op_reg) == FN_REMOVE)
        else $error("unexpected shift cycle");

endmodule
